// ===== hw/rtl/pending_transaction_table_top_defines.svh =====
// Assertion macros for the pending transaction table.
`ifndef PENDING_TRANSACTION_TABLE_TOP_DEFINES_SVH
`define PENDING_TRANSACTION_TABLE_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PTT_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("pending table check failed");
// Next-cycle implication checked outside reset.
`define PTT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pending table check failed");
`endif

// ===== hw/rtl/ptt_pkg.sv =====
// Package: types and constants of the pending transaction table.
`default_nettype none
package ptt_pkg;
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  localparam logic [1:0] ADDR_MODE_SHORT = 2'd2;
  localparam logic [1:0] ADDR_MODE_EXT   = 2'd3;
  localparam logic       FRAME_DATA_FLAG = 1'b1;

  localparam logic [2:0] RK_ADD     = 3'd0;
  localparam logic [2:0] RK_CONFIRM = 3'd1;
  localparam logic [2:0] RK_PENDING = 3'd2;
  localparam logic [2:0] RK_SUMMARY = 3'd3;
  localparam logic [2:0] RK_LOOKUP  = 3'd4;
  localparam logic [2:0] RK_REMOVE  = 3'd5;

  localparam logic STATUS_SUCCESS = 1'b0;
  localparam logic STATUS_EXPIRED = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  addr_mode;
    logic [63:0] ext_addr;
    logic [15:0] short_addr;
    logic        is_data;
    logic [7:0]  handle;
    logic [2:0]  slot_in;
  } ptt_req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic        ok;
    logic [2:0]  slot_out;
    logic [7:0]  confirm_handle;
    logic        status;
    logic [63:0] pending_addr;
    logic [3:0]  ext_count;
    logic        last;
  } ptt_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_WALK, ST_EMIT, ST_FINAL, ST_WAIT
  } ptt_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_req;   // capture the request
    logic start_walk; // set cursor to head
    logic do_add;     // perform add, stage add answer
    logic step;       // process cursor entry
    logic stage_final;// stage closing answer of walk ops
    logic out_load;   // move staged result to output register
  } ptt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk_done;  // walk ended (end of list, hit, or step bound)
    logic step_emits; // current step yields a result
    logic step_stops; // current step ends the walk after its result
  } ptt_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ptt_if.sv =====
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface ptt_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ptt_ctrl.sv =====
// Controller state machine of the pending transaction table.
`default_nettype none
`include "pending_transaction_table_top_defines.svh"
module ptt_ctrl import ptt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [1:0] req_kind,
  output logic      out_valid,
  input  wire logic out_ready,
  output ptt_cmd_t  cmd,
  input  wire ptt_sts_t sts
);
  ptt_state_t state, state_next;
  logic out_valid_next;

  // Hold state and output-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Sequence operations and emit results one by one
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load_req = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (req_kind == KIND_ADD) begin
          cmd.do_add = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.start_walk = 1'b1;
          state_next     = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          cmd.stage_final = 1'b1;
          state_next      = ST_FINAL;
        end else if (!out_valid_next) begin
          cmd.step = 1'b1;
          if (sts.step_emits) begin
            state_next = sts.step_stops ? ST_FINAL : ST_EMIT;
          end
        end
      end
      ST_EMIT, ST_FINAL: begin
        // Staged result waits for a free output register
        if (!out_valid_next) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          if (state == ST_FINAL || req_kind == KIND_ADD) state_next = ST_WAIT;
          else state_next = ST_WALK;
        end
      end
      ST_WAIT: begin
        // Last result has been loaded; return for the next transaction
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `PTT_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == ST_IDLE)
  `PTT_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, !out_valid || out_ready)
  `PTT_ASSERT_NEXT(a_load_valid, clk, rst, cmd.out_load, out_valid)
endmodule
`default_nettype wire

// ===== hw/rtl/ptt_dp.sv =====
// Datapath of the pending transaction table: slot pool, list and results.
`default_nettype none
`include "pending_transaction_table_top_defines.svh"
module ptt_dp import ptt_pkg::*; #(
  parameter int POOL_SLOTS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire ptt_req_t req_in,
  output logic [1:0] req_kind,
  input  wire ptt_cmd_t cmd,
  output ptt_sts_t  sts,
  output ptt_rsp_t  rsp
);
  localparam int SW = $clog2(POOL_SLOTS);
  localparam int LW = $clog2(POOL_SLOTS + 1);
  localparam logic [LW-1:0] NONE = LW'(POOL_SLOTS);

  logic [7:0]  persistence_time;
  ptt_req_t    req;
  logic [POOL_SLOTS-1:0] slot_valid;
  logic [7:0]  slot_ttl [POOL_SLOTS];
  logic [1:0]  slot_mode [POOL_SLOTS];
  logic [63:0] slot_ext [POOL_SLOTS];
  logic [15:0] slot_short [POOL_SLOTS];
  logic        slot_data_flag [POOL_SLOTS];
  logic [7:0]  slot_handle [POOL_SLOTS];
  logic [LW-1:0] slot_link [POOL_SLOTS];
  logic [LW-1:0] head_slot, tail_slot;
  logic [LW-1:0] cur, prev;
  logic [LW-1:0] steps;
  logic [3:0]  cnt;
  logic        done_flag;
  ptt_rsp_t    staged;
  ptt_rsp_t    staged_next;

  assign req_kind = req.kind;

  // First free slot
  logic          free_found;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Examine the cursor entry
  logic [SW-1:0] ci;
  logic cur_ok, cur_match, cur_expire, cur_ext, is_tgt;
  assign ci        = cur[SW-1:0];
  assign cur_ok    = (cur < NONE) && slot_valid[ci] && !done_flag && (steps < NONE);
  assign cur_expire = slot_ttl[ci] == 8'd0;
  assign cur_ext   = slot_mode[ci] == ADDR_MODE_EXT;
  assign cur_match = (slot_mode[ci] == req.addr_mode) &&
                     ((req.addr_mode == ADDR_MODE_EXT && slot_ext[ci] == req.ext_addr) ||
                      (req.addr_mode == ADDR_MODE_SHORT && slot_short[ci] == req.short_addr));
  assign is_tgt    = ci == req.slot_in;

  always_comb begin
    sts.walk_done  = !cur_ok;
    sts.step_emits = 1'b0;
    sts.step_stops = 1'b0;
    case (req.kind)
      KIND_TICK:   sts.step_emits = cur_expire ? slot_data_flag[ci] == FRAME_DATA_FLAG
                                               : cur_ext;
      KIND_LOOKUP: begin
        sts.step_emits = cur_match;
        sts.step_stops = cur_match;
      end
      KIND_REMOVE: begin
        sts.step_emits = is_tgt && slot_data_flag[ci] != FRAME_DATA_FLAG;
        sts.step_stops = sts.step_emits;
        if (is_tgt && slot_data_flag[ci] == FRAME_DATA_FLAG) sts.step_emits = 1'b1;
      end
      default: ;
    endcase
  end

  // Build the result for the current command
  always_comb begin
    staged_next = '0;
    if (cmd.do_add) begin
      staged_next.result_kind = RK_ADD;
      staged_next.last        = 1'b1;
      if (free_found) begin
        staged_next.ok             = 1'b1;
        staged_next.slot_out       = 3'(free_idx);
        staged_next.confirm_handle = req.handle;
      end
    end else if (cmd.step) begin
      staged_next.slot_out       = 3'(ci);
      staged_next.confirm_handle = slot_handle[ci];
      case (req.kind)
        KIND_TICK: begin
          if (cur_expire) begin
            staged_next.result_kind = RK_CONFIRM;
            staged_next.status      = STATUS_EXPIRED;
          end else begin
            staged_next.result_kind  = RK_PENDING;
            staged_next.pending_addr = slot_ext[ci];
          end
        end
        KIND_LOOKUP: begin
          staged_next.result_kind = RK_LOOKUP;
          staged_next.ok          = 1'b1;
          staged_next.last        = 1'b1;
        end
        KIND_REMOVE: begin
          if (slot_data_flag[ci] == FRAME_DATA_FLAG) begin
            // Confirm first; answer staged later by the final step
            staged_next.result_kind = RK_CONFIRM;
          end else begin
            staged_next.result_kind = RK_REMOVE;
            staged_next.ok          = 1'b1;
            staged_next.last        = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd.stage_final) begin
      staged_next.last = 1'b1;
      case (req.kind)
        KIND_TICK: begin
          staged_next.result_kind = RK_SUMMARY;
          staged_next.ext_count   = cnt;
        end
        KIND_LOOKUP: staged_next.result_kind = RK_LOOKUP;
        KIND_REMOVE: begin
          staged_next.result_kind = RK_REMOVE;
          // Data-entry remove: walk closed right after its confirm
          if (done_flag && 32'(prev) < POOL_SLOTS && prev[SW-1:0] == req.slot_in &&
              !slot_valid[prev[SW-1:0]]) begin
            staged_next.ok             = 1'b1;
            staged_next.slot_out       = req.slot_in;
            staged_next.confirm_handle = slot_handle[prev[SW-1:0]];
          end
        end
        default: ;
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) persistence_time <= 8'd255;
    else if (cfg_we) persistence_time <= cfg_wdata;
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) req <= req_in;
  end

  // List state, walk cursor and staged result
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      head_slot  <= NONE;
      tail_slot  <= NONE;
      for (int i = 0; i < POOL_SLOTS; i++) slot_link[i] <= NONE;
    end else begin
      if (cmd.do_add || cmd.step || cmd.stage_final) staged <= staged_next;
      if (cmd.do_add && free_found) begin
        slot_valid[free_idx]     <= 1'b1;
        slot_ttl[free_idx]       <= persistence_time;
        slot_mode[free_idx]      <= req.addr_mode;
        slot_ext[free_idx]       <= req.ext_addr;
        slot_short[free_idx]     <= req.short_addr;
        slot_data_flag[free_idx] <= req.is_data;
        slot_handle[free_idx]    <= req.handle;
        slot_link[free_idx]      <= NONE;
        if (head_slot == NONE || tail_slot == NONE) head_slot <= LW'(free_idx);
        else slot_link[tail_slot[SW-1:0]] <= LW'(free_idx);
        tail_slot <= LW'(free_idx);
      end
      if (cmd.start_walk) begin
        cur       <= head_slot;
        prev      <= NONE;
        steps     <= '0;
        cnt       <= '0;
        // Remove of a free slot skips the walk
        done_flag <= req.kind == KIND_REMOVE &&
                     !(32'(req.slot_in) < POOL_SLOTS && slot_valid[SW'(req.slot_in)]);
      end
      if (cmd.step) begin
        steps <= steps + 1'b1;
        cur   <= slot_link[ci];
        case (req.kind)
          KIND_TICK: begin
            if (cur_expire) begin
              if (prev == NONE) head_slot <= slot_link[ci];
              else slot_link[prev[SW-1:0]] <= slot_link[ci];
              if (tail_slot == cur) tail_slot <= prev;
              slot_valid[ci] <= 1'b0;
              slot_link[ci]  <= NONE;
            end else begin
              slot_ttl[ci] <= slot_ttl[ci] - 8'd1;
              if (cur_ext) cnt <= cnt + 4'd1;
              prev <= cur;
            end
          end
          KIND_LOOKUP: begin
            if (cur_match) done_flag <= 1'b1;
          end
          KIND_REMOVE: begin
            if (is_tgt) begin
              if (prev == NONE) head_slot <= slot_link[ci];
              else slot_link[prev[SW-1:0]] <= slot_link[ci];
              if (tail_slot == cur) tail_slot <= prev;
              slot_valid[ci] <= 1'b0;
              slot_link[ci]  <= NONE;
              done_flag <= 1'b1;
              prev <= cur; // remember target for the closing answer
            end else begin
              prev <= cur;
            end
          end
          default: ;
        endcase
      end
      if (cmd.out_load) rsp <= staged;
    end
  end

  `PTT_ASSERT_IMP(a_head_tail, clk, rst, head_slot == NONE, tail_slot == NONE)
  `PTT_ASSERT_IMP(a_empty, clk, rst, slot_valid == '0, head_slot == NONE)
  `PTT_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1,
                  $countones({cmd.do_add, cmd.step, cmd.stage_final, cmd.start_walk}) <= 1)
endmodule
`default_nettype wire

// ===== hw/rtl/pending_transaction_table_top.sv =====
// Top level of the pending transaction table.
// Channels: req (sink) carries one operation per transaction: add, tick,
// lookup or remove. rsp (source) carries result transactions; the final one
// of each operation has last set. cfg_we/cfg_wdata write the time-to-live
// given to newly added entries (reset value 255).
// The table keeps up to POOL_SLOTS entries chained in arrival order.
// An add is staged in the dispatch state and moved to the output register
// in the emit state; the next transaction is accepted after a wait state.
// Tick, lookup and remove walk the list one entry per cycle while the
// output register is free, with an emit state for each result before the
// closing one, then stage and load the closing result. Only one operation
// is in flight; req.ready is high while the block is idle and out of reset.
// Reset empties the table and clears all handshakes.
// When the receiver stalls, the result stays in the output register and
// the walk halts until the register is taken.
`default_nettype none
module pending_transaction_table_top import ptt_pkg::*; #(
  parameter int POOL_SLOTS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  ptt_if.sink       req,
  ptt_if.source     rsp,
  input  wire logic cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  ptt_cmd_t   cmd;
  ptt_sts_t   sts;
  logic [1:0] req_kind;

  ptt_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (req.valid),
    .in_ready (req.ready),
    .req_kind (req_kind),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .cmd, .sts
  );

  ptt_dp #(.POOL_SLOTS(POOL_SLOTS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .req_in  (req.payload),
    .req_kind(req_kind),
    .cmd, .sts,
    .rsp     (rsp.payload)
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the pending transaction table: directed and random operations checked against a predictor.
module tb;
  import ptt_pkg::*;

  localparam int NSLOT = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  ptt_if #(.payload_t(ptt_req_t)) req ();
  ptt_if #(.payload_t(ptt_rsp_t)) rsp ();

  pending_transaction_table_top #(.POOL_SLOTS(NSLOT)) uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Table copy held by the predictor
  logic [7:0]  ttl_init;
  logic        tbl_valid [NSLOT];
  logic [7:0]  tbl_ttl [NSLOT];
  logic [1:0]  tbl_mode [NSLOT];
  logic [63:0] tbl_ext [NSLOT];
  logic [15:0] tbl_short [NSLOT];
  logic        tbl_data [NSLOT];
  logic [7:0]  tbl_handle [NSLOT];
  int          tbl_link [NSLOT];
  int          head_idx, tail_idx;

  ptt_rsp_t expected_results [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit rsp_stall_long = 0;

  // Pick a gap: mostly zero or short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic ptt_rsp_t mk_rsp(logic [2:0] rk, logic okv, logic [2:0] sl,
                                      logic [7:0] h, logic st, logic [63:0] a,
                                      logic [3:0] c);
    ptt_rsp_t r;
    r.result_kind = rk; r.ok = okv; r.slot_out = sl; r.confirm_handle = h;
    r.status = st; r.pending_addr = a; r.ext_count = c; r.last = 1'b0;
    return r;
  endfunction

  task automatic table_clear();
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 0; tbl_link[i] = NSLOT; tbl_ttl[i] = 0; tbl_mode[i] = 0;
      tbl_ext[i] = 0; tbl_short[i] = 0; tbl_data[i] = 0; tbl_handle[i] = 0;
    end
    head_idx = NSLOT; tail_idx = NSLOT; ttl_init = 8'd255;
  endtask

  task automatic drop_entry(int cur, int prv);
    if (prv >= NSLOT) head_idx = tbl_link[cur];
    else tbl_link[prv] = tbl_link[cur];
    if (tail_idx == cur) tail_idx = prv;
    tbl_valid[cur] = 0;
    tbl_link[cur] = NSLOT;
  endtask

  // Compute the results of one operation and queue them
  task automatic predict_op(ptt_req_t t);
    ptt_rsp_t outs [$];
    int cur, prv, nxt, steps, cnt, slot;
    bit hit;
    case (t.kind)
      KIND_ADD: begin
        slot = NSLOT;
        for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
        if (slot == NSLOT) outs.push_back(mk_rsp(RK_ADD, 0, 0, 0, 0, 0, 0));
        else begin
          tbl_valid[slot] = 1; tbl_ttl[slot] = ttl_init; tbl_mode[slot] = t.addr_mode;
          tbl_ext[slot] = t.ext_addr; tbl_short[slot] = t.short_addr;
          tbl_data[slot] = t.is_data; tbl_handle[slot] = t.handle; tbl_link[slot] = NSLOT;
          if (head_idx >= NSLOT || tail_idx >= NSLOT) head_idx = slot;
          else tbl_link[tail_idx] = slot;
          tail_idx = slot;
          outs.push_back(mk_rsp(RK_ADD, 1, slot[2:0], t.handle, 0, 0, 0));
        end
      end
      KIND_TICK: begin
        cnt = 0; cur = head_idx; prv = NSLOT; steps = 0;
        while (steps < NSLOT && cur < NSLOT && tbl_valid[cur]) begin
          nxt = tbl_link[cur];
          if (tbl_ttl[cur] == 0) begin
            if (tbl_data[cur] == FRAME_DATA_FLAG)
              outs.push_back(mk_rsp(RK_CONFIRM, 0, cur[2:0], tbl_handle[cur],
                                    STATUS_EXPIRED, 0, 0));
            drop_entry(cur, prv);
          end else begin
            tbl_ttl[cur] = tbl_ttl[cur] - 8'd1;
            if (tbl_mode[cur] == ADDR_MODE_EXT) begin
              outs.push_back(mk_rsp(RK_PENDING, 0, cur[2:0], tbl_handle[cur], 0,
                                    tbl_ext[cur], 0));
              cnt++;
            end
            prv = cur;
          end
          cur = nxt; steps++;
        end
        outs.push_back(mk_rsp(RK_SUMMARY, 0, 0, 0, 0, 0, cnt[3:0]));
      end
      KIND_LOOKUP: begin
        hit = 0; cur = head_idx; steps = 0;
        while (steps < NSLOT && cur < NSLOT && tbl_valid[cur] && !hit) begin
          if (tbl_mode[cur] == t.addr_mode &&
              ((t.addr_mode == ADDR_MODE_EXT && tbl_ext[cur] == t.ext_addr) ||
               (t.addr_mode == ADDR_MODE_SHORT && tbl_short[cur] == t.short_addr)))
            hit = 1;
          else begin
            cur = tbl_link[cur]; steps++;
          end
        end
        if (hit) outs.push_back(mk_rsp(RK_LOOKUP, 1, cur[2:0], tbl_handle[cur], 0, 0, 0));
        else outs.push_back(mk_rsp(RK_LOOKUP, 0, 0, 0, 0, 0, 0));
      end
      default: begin
        hit = 0;
        if (tbl_valid[t.slot_in]) begin
          cur = head_idx; prv = NSLOT; steps = 0;
          while (!hit && steps < NSLOT && cur < NSLOT && tbl_valid[cur]) begin
            if (cur == t.slot_in) begin
              if (tbl_data[cur] == FRAME_DATA_FLAG)
                outs.push_back(mk_rsp(RK_CONFIRM, 0, cur[2:0], tbl_handle[cur],
                                      STATUS_SUCCESS, 0, 0));
              outs.push_back(mk_rsp(RK_REMOVE, 1, cur[2:0], tbl_handle[cur], 0, 0, 0));
              drop_entry(cur, prv);
              hit = 1;
            end else begin
              prv = cur; cur = tbl_link[cur]; steps++;
            end
          end
        end
        if (!hit) outs.push_back(mk_rsp(RK_REMOVE, 0, 0, 0, 0, 0, 0));
      end
    endcase
    outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
  endtask

  // Send one transaction, predicting at acceptance; valid drops only for a gap
  task automatic send_op(ptt_req_t t);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= t;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_op(t);
  endtask

  function automatic ptt_req_t mk_op(logic [1:0] k, logic [1:0] m, logic [63:0] e,
                                     logic [15:0] s, logic d, logic [7:0] h,
                                     logic [2:0] sl);
    ptt_req_t t;
    t.kind = k; t.addr_mode = m; t.ext_addr = e; t.short_addr = s;
    t.is_data = d; t.handle = h; t.slot_in = sl;
    return t;
  endfunction

  // Wait for the block to drain, then write the TTL register
  task automatic set_ttl(logic [7:0] v);
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ttl_init = v;
  endtask

  // Result checker
  always @(posedge clk) begin
    ptt_rsp_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp.payload);
      end else begin
        exp_r = expected_results.pop_front();
        if (rsp.payload !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", exp_r, rsp.payload);
        end
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    int g;
    if (rst) rsp.ready <= 1'b0;
    else if (rsp.ready && rsp.valid) begin
      g = pick_gap();
      if (g == 0) rsp.ready <= 1'b1;
      else begin
        rsp.ready <= 1'b0;
        repeat (g) @(posedge clk);
        rsp.ready <= 1'b1;
      end
    end else rsp.ready <= 1'b1;
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    send_op(mk_op(KIND_TICK, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(KIND_REMOVE, 0, 0, 0, 0, 0, 3'd7));
    send_op(mk_op(KIND_LOOKUP, ADDR_MODE_SHORT, 0, 16'hffff, 0, 0, 0));
    send_op(mk_op(KIND_ADD, ADDR_MODE_EXT, 64'hffff_ffff_ffff_ffff, 16'hffff, 1,
                  8'hff, 0));
    send_op(mk_op(KIND_ADD, ADDR_MODE_SHORT, 64'h0, 16'h0000, 0, 8'h00, 0));
    send_op(mk_op(KIND_ADD, 2'd0, 64'h1234, 16'h1234, 1, 8'h5a, 0));
    send_op(mk_op(KIND_ADD, 2'd1, 64'h1234, 16'h1234, 0, 8'ha5, 0));
    for (int i = 0; i < 5; i++)
      send_op(mk_op(KIND_ADD, ADDR_MODE_EXT, {$urandom, $urandom}, 16'(i), i[0],
                    8'(i + 1), 0));
    send_op(mk_op(KIND_ADD, ADDR_MODE_SHORT, 0, 0, 0, 0, 0));
    send_op(mk_op(KIND_LOOKUP, ADDR_MODE_EXT, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0));
    send_op(mk_op(KIND_LOOKUP, ADDR_MODE_SHORT, 0, 16'h0000, 0, 0, 0));
    send_op(mk_op(KIND_LOOKUP, 2'd0, 64'h1234, 16'h1234, 0, 0, 0));
    send_op(mk_op(KIND_LOOKUP, 2'd1, 64'h1234, 16'h1234, 0, 0, 0));
    send_op(mk_op(KIND_TICK, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(KIND_REMOVE, 0, 0, 0, 0, 0, 3'd0));
    send_op(mk_op(KIND_REMOVE, 0, 0, 0, 0, 0, 3'd1));
    send_op(mk_op(KIND_REMOVE, 0, 0, 0, 0, 0, 3'd0));
    send_op(mk_op(KIND_REMOVE, 0, 0, 0, 0, 0, 3'd7));
  endtask

  // Expiry: TTL zero drops entries on the next tick
  task automatic test_expiry();
    set_ttl(8'd0);
    for (int i = 0; i < 4; i++)
      send_op(mk_op(KIND_ADD, ADDR_MODE_EXT, 64'(i), 0, i[0], 8'(8'h80 + i), 0));
    send_op(mk_op(KIND_TICK, 0, 0, 0, 0, 0, 0));
    send_op(mk_op(KIND_TICK, 0, 0, 0, 0, 0, 0));
  endtask

  // Random mix with a small pool of addresses so lookups hit
  task automatic test_random(int n, logic [7:0] ttl);
    logic [63:0] ext_pool [4];
    logic [15:0] short_pool [4];
    ptt_req_t t;
    int r;
    set_ttl(ttl);
    foreach (ext_pool[i]) begin
      ext_pool[i] = {$urandom, $urandom};
      short_pool[i] = 16'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      t = mk_op(2'($urandom), 2'($urandom), {$urandom, $urandom}, 16'($urandom),
                1'($urandom), 8'($urandom), 3'($urandom));
      r = $urandom_range(0, 99);
      if (r < 35) t.kind = KIND_ADD;
      else if (r < 60) t.kind = KIND_TICK;
      else if (r < 80) t.kind = KIND_LOOKUP;
      else t.kind = KIND_REMOVE;
      if ($urandom_range(0, 3) != 0) begin
        t.ext_addr = ext_pool[$urandom_range(0, 3)];
        t.short_addr = short_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 3) != 0) t.addr_mode = 2'($urandom_range(2, 3));
      end
      send_op(t);
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.payload = '0;
    table_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_expiry();
    test_random(100, 8'd3);
    test_random(90, 8'd1);
    test_random(90, 8'd255);
    test_random(90, 8'd0);
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
